// ===== hw/rtl/c2p_pkg.sv =====
// Shared types and helpers for the conservative-to-primitive converter.
`timescale 1ns / 1ps
package c2p_pkg;

  localparam int GAMMA_W = 18;
  localparam int RHO_W   = 31;
  localparam int VAL_W   = 32;
  localparam logic [GAMMA_W-1:0] GAMMA_RESET = 18'd91750;

  // Lane order inside an item: three momentum components, then energy.
  localparam int LANES  = 4;
  localparam int LANE_E = 3;

  // One classified word as it leaves the front end.
  typedef struct packed {
    logic [RHO_W-1:0]              rho;
    logic                          zero;
    logic [LANES-1:0]              neg;
    logic [LANES-1:0][VAL_W-1:0]   mag;
  } c2p_item_t;

  // Queue status seen by the front and back ends.
  typedef struct packed {
    logic empty;
    logic full;
  } c2p_qstat_t;

  // Clip a sign/magnitude value to signed 32 bits; bit 32 is the clip flag.
  function automatic logic [VAL_W:0] clip32(input logic neg, input logic [63:0] mag);
    logic [VAL_W-1:0] val;
    logic             sat;
    begin
      sat = 1'b0;
      if (neg) begin
        if (mag > 64'h8000_0000) begin
          val = 32'h8000_0000;
          sat = 1'b1;
        end else begin
          val = 32'(64'd0 - mag);
        end
      end else begin
        if (mag > 64'h7FFF_FFFF) begin
          val = 32'h7FFF_FFFF;
          sat = 1'b1;
        end else begin
          val = mag[VAL_W-1:0];
        end
      end
      return {sat, val};
    end
  endfunction

endpackage

// ===== hw/rtl/conservative_to_primitive_top.sv =====
// Stages: the front register, the queue, 32+FRACTION_BITS divider stages, then 7 stages.
// Throughput: one word per cycle while the output is taken; the divider is fully pipelined, one quotient bit a stage.
// The back pipeline advances as a whole whenever the output register is empty or taken.
// Reset (rst, synchronous) empties the front register, queue and pipeline valids,
// and sets gas_gamma to 1.4 in unsigned Q2.16.
`timescale 1ns / 1ps
module conservative_to_primitive_top #(
  parameter int FRACTION_BITS = 16,
  parameter int QUEUE_DEPTH   = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          gas_gamma_we,
  input  logic [c2p_pkg::GAMMA_W-1:0]   gas_gamma_wdata,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // density, momentum_x, momentum_y, momentum_z, energy_density, zero pad
  input  logic [159:0]                  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // velocity_x, velocity_y, velocity_z, temperature, pressure
  output logic [159:0]                  m_axis_tdata,
  // zero_density, saturated
  output logic [1:0]                    m_axis_tuser
);

  logic [c2p_pkg::GAMMA_W-1:0] gas_gamma;
  c2p_pkg::c2p_qstat_t         qstat;
  c2p_pkg::c2p_item_t          f_item;
  c2p_pkg::c2p_item_t          q_head;
  logic                        f_push;
  logic                        b_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      gas_gamma <= c2p_pkg::GAMMA_RESET;
    end else if (gas_gamma_we) begin
      gas_gamma <= gas_gamma_wdata;
    end
  end

  c2p_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
    .qstat(qstat), .push(f_push), .item(f_item)
  );

  c2p_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst),
    .push(f_push), .push_item(f_item), .pop(b_pop), .head(q_head), .qstat(qstat)
  );

  c2p_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk(clk), .rst(rst), .gas_gamma(gas_gamma),
    .qstat(qstat), .head(q_head), .pop(b_pop),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_data(m_axis_tdata), .out_user(m_axis_tuser)
  );

endmodule

// ===== hw/rtl/c2p_front.sv =====
// Front end: takes input words and splits them into signs and magnitudes.
`timescale 1ns / 1ps
module c2p_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [159:0]         in_data,
  input  c2p_pkg::c2p_qstat_t  qstat,
  output logic                 push,
  output c2p_pkg::c2p_item_t   item
);

  logic               held;
  c2p_pkg::c2p_item_t word;
  c2p_pkg::c2p_item_t word_next;
  logic [31:0]        raw [c2p_pkg::LANES];

  assign raw[0] = in_data[62:31];
  assign raw[1] = in_data[94:63];
  assign raw[2] = in_data[126:95];
  assign raw[3] = in_data[158:127];

  always_comb begin
    word_next.rho  = in_data[30:0];
    word_next.zero = (in_data[30:0] == '0);
    for (int i = 0; i < c2p_pkg::LANES; i++) begin
      word_next.neg[i] = raw[i][31];
      word_next.mag[i] = raw[i][31] ? 32'(32'd0 - raw[i]) : raw[i];
    end
  end

  assign push     = held && !qstat.full;
  assign in_ready = !held || !qstat.full;
  assign item     = word;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word <= word_next;
    end
  end

endmodule

// ===== hw/rtl/c2p_queue.sv =====
// Short queue between the front and back ends.
`timescale 1ns / 1ps
module c2p_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  c2p_pkg::c2p_item_t  push_item,
  input  logic                pop,
  output c2p_pkg::c2p_item_t  head,
  output c2p_pkg::c2p_qstat_t qstat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  c2p_pkg::c2p_item_t slots [DEPTH];
  logic [AW-1:0]      wr_ptr;
  logic [AW-1:0]      rd_ptr;
  logic [AW:0]        count;
  logic               do_push;
  logic               do_pop;

  assign qstat.empty = (count == '0);
  assign qstat.full  = (count == (AW+1)'(DEPTH));
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH)) else $error("queue count above depth");
  a_ptr_agree: assert property (@(posedge clk) disable iff (rst)
    qstat.empty |-> (wr_ptr == rd_ptr)) else $error("empty queue with unequal pointers");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count missed a push");

endmodule

// ===== hw/rtl/c2p_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, several lanes share a divisor.
`timescale 1ns / 1ps
module c2p_div #(
  parameter int NW = 48,
  parameter int TW = 5
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic [c2p_pkg::RHO_W-1:0]             in_rho,
  input  logic [c2p_pkg::LANES-1:0][NW-1:0]     in_num,
  input  logic [TW-1:0]                         in_tag,
  output logic                                  out_valid,
  output logic [c2p_pkg::RHO_W-1:0]             out_rho,
  output logic [c2p_pkg::LANES-1:0][NW-1:0]     out_quo,
  output logic [TW-1:0]                         out_tag
);

  localparam int RW = c2p_pkg::RHO_W;
  localparam int L  = c2p_pkg::LANES;

  // The shift word holds untouched numerator bits on top and quotient bits below.
  logic                     vld [NW+1];
  logic [RW-1:0]            rho [NW+1];
  logic [TW-1:0]            tag [NW+1];
  logic [L-1:0][RW-1:0]     rem [NW+1];
  logic [L-1:0][NW-1:0]     nq  [NW+1];

  assign vld[0] = in_valid;
  assign rho[0] = in_rho;
  assign tag[0] = in_tag;
  assign rem[0] = '0;
  assign nq[0]  = in_num;

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [L-1:0][RW-1:0] rem_next;
    logic [L-1:0][NW-1:0] nq_next;

    always_comb begin
      logic [RW:0] trial;
      logic        ge;
      for (int i = 0; i < L; i++) begin
        trial = {rem[k][i], nq[k][i][NW-1]};
        ge    = (trial >= {1'b0, rho[k]});
        rem_next[i] = ge ? RW'(trial - {1'b0, rho[k]}) : trial[RW-1:0];
        nq_next[i]  = {nq[k][i][NW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rho[k+1] <= rho[k];
        tag[k+1] <= tag[k];
        rem[k+1] <= rem_next;
        nq[k+1]  <= nq_next;
      end
    end
  end

  assign out_valid = vld[NW];
  assign out_rho   = rho[NW];
  assign out_tag   = tag[NW];
  assign out_quo   = nq[NW];

endmodule

// ===== hw/rtl/c2p_back.sv =====
// Back end: division, kinetic energy, temperature and pressure, with output register.
`timescale 1ns / 1ps
module c2p_back #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [c2p_pkg::GAMMA_W-1:0]    gas_gamma,
  input  c2p_pkg::c2p_qstat_t            qstat,
  input  c2p_pkg::c2p_item_t             head,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [159:0]                   out_data,
  output logic [1:0]                     out_user
);

  localparam int F   = FRACTION_BITS;
  localparam int NW  = 32 + F;
  localparam int L   = c2p_pkg::LANES;
  localparam int TW  = L + 1;
  localparam int IW  = 67;
  localparam int BW  = (c2p_pkg::GAMMA_W > F) ? c2p_pkg::GAMMA_W : F + 1;
  localparam int HW  = IW - 1 - 32;

  logic en;
  assign en  = !out_valid || out_ready;
  assign pop = en && !qstat.empty;

  // Divider feed: magnitudes scaled by the fraction width.
  logic [L-1:0][NW-1:0] num;
  always_comb begin
    for (int i = 0; i < L; i++) begin
      num[i] = {head.mag[i], F'(0)};
    end
  end

  logic                 d_valid;
  logic [30:0]          d_rho;
  logic [L-1:0][NW-1:0] d_quo;
  logic [TW-1:0]        d_tag;

  c2p_div #(.NW(NW), .TW(TW)) u_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(pop), .in_rho(head.rho), .in_num(num), .in_tag({head.zero, head.neg}),
    .out_valid(d_valid), .out_rho(d_rho), .out_quo(d_quo), .out_tag(d_tag)
  );

  // Gamma minus one; the user must change the register only while the pipe is empty (not enforced here).
  logic signed [BW+1:0] gm1;
  logic                 gneg;
  logic [BW-1:0]        gmag;
  assign gm1  = $signed({(BW+2-c2p_pkg::GAMMA_W)'(0), gas_gamma}) - (BW+2)'(64'd1 << F);
  assign gneg = gm1[BW+1];
  assign gmag = BW'(gneg ? -gm1 : gm1);

  // Stage 1: clip velocities, sign the energy quotient.
  logic                 s1_v, s1_zero, s1_sat;
  logic [30:0]          s1_rho;
  logic [2:0][31:0]     s1_vel;
  logic signed [IW-1:0] s1_q;
  // Stage 2: squares.
  logic                 s2_v, s2_zero, s2_sat;
  logic [30:0]          s2_rho;
  logic [2:0][31:0]     s2_vel;
  logic [2:0][63:0]     s2_sq;
  logic signed [IW-1:0] s2_q;
  // Stage 3: internal energy.
  logic                 s3_v, s3_zero, s3_sat, s3_ineg;
  logic [30:0]          s3_rho;
  logic [2:0][31:0]     s3_vel;
  logic [IW-2:0]        s3_a;
  // Stage 4: partial products with gamma minus one.
  logic                 s4_v, s4_zero, s4_sat, s4_sgn;
  logic [30:0]          s4_rho;
  logic [2:0][31:0]     s4_vel;
  logic [32+BW-1:0]     s4_plo;
  logic [HW+BW-1:0]     s4_phi;
  // Stage 5: temperature.
  logic                 s5_v, s5_zero, s5_sat;
  logic [30:0]          s5_rho;
  logic [2:0][31:0]     s5_vel;
  logic [31:0]          s5_temp;
  // Stage 6: pressure product.
  logic                 s6_v, s6_zero, s6_sat;
  logic [2:0][31:0]     s6_vel;
  logic [31:0]          s6_temp;
  logic [62:0]          s6_prod;
  // Output register.
  logic                 o_zero, o_sat;
  logic [2:0][31:0]     o_vel;
  logic [31:0]          o_temp, o_pres;

  logic [2:0][32:0]     vclip;
  logic [NW:0]          qmag_x;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vclip[i] = c2p_pkg::clip32(d_tag[i], 64'(d_quo[i]));
    end
    qmag_x = {1'b0, d_quo[c2p_pkg::LANE_E]};
  end

  logic [63:0]          ksum;
  logic signed [IW-1:0] internal;
  assign ksum     = s2_sq[0] + s2_sq[1] + s2_sq[2];
  assign internal = s2_q - $signed(IW'(ksum >> (F + 1)));

  logic [63:0] tmag;
  logic [32:0] tclip;
  always_comb begin
    if ((s4_phi >> F) != '0) begin
      tmag = 64'd1 << 40;
    end else begin
      tmag = (64'(s4_phi) << (32 - F)) + (64'(s4_plo) >> F);
    end
    tclip = c2p_pkg::clip32((tmag != '0) && s4_sgn, tmag);
  end

  logic [31:0] tabs;
  assign tabs = s5_temp[31] ? 32'(32'd0 - s5_temp) : s5_temp;

  logic [63:0] pmag;
  logic [32:0] pclip;
  assign pmag  = 64'(s6_prod >> F);
  assign pclip = c2p_pkg::clip32((pmag != '0) && s6_temp[31], pmag);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0; s2_v <= 1'b0; s3_v <= 1'b0;
      s4_v <= 1'b0; s5_v <= 1'b0; s6_v <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_v <= d_valid; s2_v <= s1_v; s3_v <= s2_v;
      s4_v <= s3_v; s5_v <= s4_v; s6_v <= s5_v;
      out_valid <= s6_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_zero <= d_tag[L];
      s1_rho  <= d_rho;
      s1_sat  <= vclip[0][32] | vclip[1][32] | vclip[2][32];
      for (int i = 0; i < 3; i++) begin
        s1_vel[i] <= vclip[i][31:0];
      end
      s1_q <= d_tag[c2p_pkg::LANE_E] ? -$signed(IW'(qmag_x)) : $signed(IW'(qmag_x));

      s2_zero <= s1_zero; s2_rho <= s1_rho; s2_sat <= s1_sat;
      s2_vel  <= s1_vel;  s2_q   <= s1_q;
      for (int i = 0; i < 3; i++) begin
        s2_sq[i] <= 64'(s1_vel[i][31] ? 32'(32'd0 - s1_vel[i]) : s1_vel[i]) *
                    64'(s1_vel[i][31] ? 32'(32'd0 - s1_vel[i]) : s1_vel[i]);
      end

      s3_zero <= s2_zero; s3_rho <= s2_rho; s3_sat <= s2_sat; s3_vel <= s2_vel;
      s3_ineg <= internal[IW-1];
      s3_a    <= (IW-1)'(internal[IW-1] ? -internal : internal);

      s4_zero <= s3_zero; s4_rho <= s3_rho; s4_sat <= s3_sat; s4_vel <= s3_vel;
      s4_sgn  <= s3_ineg != gneg;
      s4_plo  <= (32+BW)'(s3_a[31:0]) * (32+BW)'(gmag);
      s4_phi  <= (HW+BW)'(s3_a[IW-2:32]) * (HW+BW)'(gmag);

      s5_zero <= s4_zero; s5_rho <= s4_rho; s5_vel <= s4_vel;
      s5_sat  <= s4_sat | tclip[32];
      s5_temp <= tclip[31:0];

      s6_zero <= s5_zero; s6_sat <= s5_sat; s6_vel <= s5_vel; s6_temp <= s5_temp;
      s6_prod <= 63'(s5_rho) * 63'(tabs);

      // Zero density forces every value to zero and clears the clip flag.
      o_zero <= s6_zero;
      o_sat  <= s6_zero ? 1'b0 : (s6_sat | pclip[32]);
      o_vel  <= s6_zero ? '0 : s6_vel;
      o_temp <= s6_zero ? '0 : s6_temp;
      o_pres <= s6_zero ? '0 : pclip[31:0];
    end
  end

  assign out_data = {o_pres, o_temp, o_vel[2], o_vel[1], o_vel[0]};
  assign out_user = {o_sat, o_zero};

  a_zero_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && o_zero) |-> (!o_sat && out_data == '0))
    else $error("zero-density word carries data or clip flag");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data) && $stable(out_user)))
    else $error("output word changed while stalled");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (s6_v && out_valid && !out_ready) |=> s6_v)
    else $error("pipeline lost a word while stalled");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty) else $error("pop from empty queue");

endmodule
